// File: rtl/bta_pkg.sv
// Shared types, codes and sizing constants of the boundary-tag heap allocator.
`timescale 1ns / 1ps
`default_nettype none

package bta_pkg;

  // Heap geometry
  localparam int HEAP_WORDS = 4096;
  localparam int WADDR_W    = $clog2(HEAP_WORDS);
  // Byte address plus headroom for header + size + framing sums
  localparam int BA_W       = WADDR_W + 4;
  // Field and tag widths
  localparam int SZ_W       = 14;
  localparam int WORD_W     = SZ_W;
  localparam int TYPE_W     = 2;
  localparam int ST_W       = 2;

  localparam logic [SZ_W-1:0] POOL_RESET = SZ_W'(1024);
  localparam logic [BA_W-1:0] POOL_MAX   = BA_W'((HEAP_WORDS * 4 - 24) & ~7);

  // Request codes
  localparam logic [TYPE_W-1:0] REQ_ALLOC  = TYPE_W'(0);
  localparam logic [TYPE_W-1:0] REQ_FREE   = TYPE_W'(1);
  localparam logic [TYPE_W-1:0] REQ_FORMAT = TYPE_W'(2);

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK      = ST_W'(0);
  localparam logic [ST_W-1:0] ST_NOFIT   = ST_W'(1);
  localparam logic [ST_W-1:0] ST_INVALID = ST_W'(2);

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [SZ_W-1:0]   request_bytes;
    logic [SZ_W-1:0]   block_offset;
  } req_t;

  typedef struct packed {
    logic [SZ_W-1:0] payload_offset;
    logic [ST_W-1:0] status;
  } rsp_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_FMT_START,
    DP_SWEEP,
    DP_A_RD,
    DP_A_EV,
    DP_A_W0,
    DP_A_W1,
    DP_A_W2,
    DP_A_W3,
    DP_F_RDH,
    DP_F_EVH,
    DP_F_RDF,
    DP_F_RDP,
    DP_F_EVP,
    DP_F_RDQ,
    DP_F_EVQ,
    DP_F_RDN,
    DP_F_EVN,
    DP_F_W0,
    DP_F_W1,
    DP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [ST_W-1:0] fin_st;
    logic            fin_off;
  } cmd_t;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic              req_zero;
    logic              off_bad;
    logic              sweep_last;
    logic              walk_end;
    logic              alloc_broken;
    logic              alloc_fit;
    logic              split;
    logic              hdr_bad;
    logic              ftr_bad;
    logic              prev_ok;
    logic              next_ok;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/bta_dp.sv
// Datapath of the heap allocator: heap memory, walk and tag registers, result register.
`timescale 1ns / 1ps
`default_nettype none

module bta_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [bta_pkg::SZ_W-1:0] cfg_wr_data,
  input  bta_pkg::req_t            in_data,
  input  bta_pkg::cmd_t            cmd,
  output bta_pkg::sts_t            sts,
  output bta_pkg::rsp_t            out_data
);
  import bta_pkg::*;

  // Heap memory
  logic [WORD_W-1:0] mem [HEAP_WORDS];
  logic [WORD_W-1:0] rdata_r;

  // Control state
  logic [SZ_W-1:0]    cfg_pool_r;
  logic [SZ_W-1:0]    fmt_pool_r;
  logic [BA_W-1:0]    heap_end_r;
  logic [WADDR_W-1:0] clr_cnt_r;

  // Per-request payload state
  req_t              req_r;
  logic [SZ_W:0]     need_r;
  logic [BA_W-1:0]   p_r;
  logic [SZ_W-1:0]   s_r;
  logic [WORD_W-1:0] h_r;
  logic [SZ_W-1:0]   size_r;
  logic [SZ_W-1:0]   ps_r;
  logic [SZ_W-1:0]   ns_r;
  logic              prev_free_r;
  logic              next_free_r;
  rsp_t              out_r;

  // Combinational helpers
  logic [SZ_W-1:0]    pool_req;
  logic [SZ_W-1:0]    pool_clamped;
  logic [SZ_W-1:0]    rd_size;
  logic [SZ_W-1:0]    take;
  logic [SZ_W-1:0]    rem_size;
  logic [SZ_W:0]      need_sum;
  logic [SZ_W:0]      need;
  logic [BA_W-1:0]    hdr;
  logic [BA_W-1:0]    phdr;
  logic [BA_W-1:0]    nhdr;
  logic [BA_W-1:0]    start;
  logic [BA_W-1:0]    total;
  logic [BA_W-1:0]    fmt_b;
  logic [BA_W-1:0]    fmt_p;
  logic [WORD_W-1:0]  fmt_val;
  logic               mem_we;
  logic               mem_re;
  logic [BA_W-1:0]    wbyte;
  logic [BA_W-1:0]    rbyte;
  logic [WORD_W-1:0]  wdata;
  logic [WADDR_W-1:0] waddr;
  logic [WADDR_W-1:0] raddr;

  function automatic logic [WORD_W-1:0] tag_word(logic [SZ_W-1:0] size, logic used);
    return {size[SZ_W-1:3], 2'b00, used};
  endfunction

  // Clamp the configured pool to what fits with the framing blocks
  assign pool_req     = {cfg_pool_r[SZ_W-1:3], 3'b000};
  assign pool_clamped = (BA_W'(pool_req) > POOL_MAX) ? POOL_MAX[SZ_W-1:0] : pool_req;

  // Round the request up to a multiple of 8
  assign need_sum = {1'b0, in_data.request_bytes} + (SZ_W+1)'(7);
  assign need     = {need_sum[SZ_W:3], 3'b000};

  assign rd_size  = {rdata_r[WORD_W-1:3], 3'b000};
  assign take     = (BA_W'(s_r) <= BA_W'(need_r) + BA_W'(8)) ? s_r : need_r[SZ_W-1:0];
  assign rem_size = s_r - take - SZ_W'(8);

  // Free-side block addresses and merged size
  assign hdr   = BA_W'(req_r.block_offset) - BA_W'(4);
  assign phdr  = hdr - BA_W'(ps_r) - BA_W'(8);
  assign nhdr  = hdr + BA_W'(size_r) + BA_W'(8);
  assign start = prev_free_r ? phdr : hdr;
  assign total = BA_W'(size_r)
               + (prev_free_r ? BA_W'(ps_r) + BA_W'(8) : BA_W'(0))
               + (next_free_r ? BA_W'(ns_r) + BA_W'(8) : BA_W'(0));

  // Formatted image of the word under the clear counter
  assign fmt_b = BA_W'({clr_cnt_r, 2'b00});
  assign fmt_p = BA_W'(fmt_pool_r);
  always_comb begin
    if (fmt_b == BA_W'(0) || fmt_b == BA_W'(4)) begin
      fmt_val = tag_word(SZ_W'(0), 1'b1);
    end else if (fmt_b == BA_W'(8) || fmt_b == fmt_p + BA_W'(12)) begin
      fmt_val = tag_word(fmt_pool_r, 1'b0);
    end else if (fmt_b == fmt_p + BA_W'(16) || fmt_b == fmt_p + BA_W'(20)) begin
      fmt_val = tag_word(SZ_W'(0), 1'b1);
    end else begin
      fmt_val = '0;
    end
  end

  // Memory port steering
  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    wbyte  = '0;
    rbyte  = '0;
    wdata  = '0;
    case (cmd.op)
      DP_SWEEP: begin
        mem_we = 1'b1;
        wbyte  = fmt_b;
        wdata  = fmt_val;
      end
      DP_A_RD: begin
        mem_re = 1'b1;
        rbyte  = p_r;
      end
      DP_A_W0: begin
        mem_we = 1'b1;
        wbyte  = p_r;
        wdata  = tag_word(take, 1'b1);
      end
      DP_A_W1: begin
        mem_we = 1'b1;
        wbyte  = p_r + BA_W'(4) + BA_W'(take);
        wdata  = tag_word(take, 1'b1);
      end
      DP_A_W2: begin
        mem_we = 1'b1;
        wbyte  = p_r + BA_W'(take) + BA_W'(8);
        wdata  = tag_word(rem_size, 1'b0);
      end
      DP_A_W3: begin
        mem_we = 1'b1;
        wbyte  = p_r + BA_W'(4) + BA_W'(s_r);
        wdata  = tag_word(rem_size, 1'b0);
      end
      DP_F_RDH: begin
        mem_re = 1'b1;
        rbyte  = hdr;
      end
      DP_F_RDF: begin
        mem_re = 1'b1;
        rbyte  = hdr + BA_W'(4) + BA_W'(size_r);
      end
      DP_F_RDP: begin
        mem_re = 1'b1;
        rbyte  = hdr - BA_W'(4);
      end
      DP_F_RDQ: begin
        mem_re = 1'b1;
        rbyte  = phdr;
      end
      DP_F_RDN: begin
        mem_re = 1'b1;
        rbyte  = nhdr;
      end
      DP_F_W0: begin
        mem_we = 1'b1;
        wbyte  = start;
        wdata  = tag_word(total[SZ_W-1:0], 1'b0);
      end
      DP_F_W1: begin
        mem_we = 1'b1;
        wbyte  = start + BA_W'(4) + total;
        wdata  = tag_word(total[SZ_W-1:0], 1'b0);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign waddr = wbyte[WADDR_W+1:2];
  assign raddr = rbyte[WADDR_W+1:2];

  // Heap memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Status to the controller
  always_comb begin
    sts.req_type     = req_r.req_type;
    sts.req_zero     = (req_r.request_bytes == '0);
    sts.off_bad      = (req_r.block_offset == '0) || (req_r.block_offset[2:0] != 3'd4) ||
                       (req_r.block_offset < SZ_W'(12));
    sts.sweep_last   = (clr_cnt_r == WADDR_W'(HEAP_WORDS - 1));
    sts.walk_end     = (p_r + BA_W'(8) > heap_end_r);
    sts.alloc_broken = (p_r + BA_W'(rd_size) + BA_W'(8) > heap_end_r);
    sts.alloc_fit    = !rdata_r[0] && ({1'b0, rd_size} >= need_r);
    sts.split        = (take < s_r);
    sts.hdr_bad      = !rdata_r[0] || (rd_size == '0) ||
                       (hdr + BA_W'(rd_size) + BA_W'(8) > heap_end_r);
    sts.ftr_bad      = (rdata_r != h_r);
    sts.prev_ok      = (BA_W'(rd_size) + BA_W'(8) <= hdr);
    sts.next_ok      = (nhdr + BA_W'(8) <= heap_end_r);
  end

  // Configuration and format bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_pool_r <= POOL_RESET;
      fmt_pool_r <= POOL_RESET;
      heap_end_r <= BA_W'(POOL_RESET) + BA_W'(24);
      clr_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        cfg_pool_r <= cfg_wr_data;
      end
      case (cmd.op)
        DP_FMT_START: begin
          fmt_pool_r <= pool_clamped;
          heap_end_r <= BA_W'(pool_clamped) + BA_W'(24);
          clr_cnt_r  <= '0;
        end
        DP_SWEEP: begin
          clr_cnt_r <= clr_cnt_r + WADDR_W'(1);
        end
        default: begin
          clr_cnt_r <= clr_cnt_r;
        end
      endcase
    end
  end

  // Request payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        req_r       <= in_data;
        need_r      <= need;
        p_r         <= BA_W'(8);
        prev_free_r <= 1'b0;
        next_free_r <= 1'b0;
      end
      DP_A_EV: begin
        s_r <= rd_size;
        // Advance to the next block unless this one is taken
        if (!sts.alloc_fit) begin
          p_r <= p_r + BA_W'(rd_size) + BA_W'(8);
        end
      end
      DP_F_EVH: begin
        h_r    <= rdata_r;
        size_r <= rd_size;
      end
      DP_F_EVP: begin
        ps_r <= rd_size;
      end
      DP_F_EVQ: begin
        prev_free_r <= !rdata_r[0];
      end
      DP_F_EVN: begin
        ns_r        <= rd_size;
        next_free_r <= !rdata_r[0] && (nhdr + BA_W'(rd_size) + BA_W'(8) <= heap_end_r);
      end
      DP_FIN: begin
        out_r.status         <= cmd.fin_st;
        out_r.payload_offset <= cmd.fin_off ? SZ_W'(p_r + BA_W'(4)) : '0;
      end
      default: begin
        s_r <= s_r;
      end
    endcase
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// File: rtl/bta_ctrl.sv
// Controller state machine of the heap allocator: sequences reads, writes and results.
`timescale 1ns / 1ps
`default_nettype none

module bta_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  bta_pkg::sts_t sts,
  output bta_pkg::cmd_t cmd
);
  import bta_pkg::*;

  typedef enum logic [22:0] {
    S_CLR   = 23'h000001,
    S_IDLE  = 23'h000002,
    S_DEC   = 23'h000004,
    S_FMT   = 23'h000008,
    S_A_RD  = 23'h000010,
    S_A_EV  = 23'h000020,
    S_A_W0  = 23'h000040,
    S_A_W1  = 23'h000080,
    S_A_W2  = 23'h000100,
    S_A_W3  = 23'h000200,
    S_F_RDH = 23'h000400,
    S_F_EVH = 23'h000800,
    S_F_RDF = 23'h001000,
    S_F_EVF = 23'h002000,
    S_F_RDP = 23'h004000,
    S_F_EVP = 23'h008000,
    S_F_RDQ = 23'h010000,
    S_F_EVQ = 23'h020000,
    S_F_RDN = 23'h040000,
    S_F_EVN = 23'h080000,
    S_F_W0  = 23'h100000,
    S_F_W1  = 23'h200000,
    S_FIN   = 23'h400000
  } state_t;

  state_t          state_r,     state_nxt;
  logic [ST_W-1:0] fin_st_r,    fin_st_nxt;
  logic            fin_off_r,   fin_off_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    fin_st_nxt    = fin_st_r;
    fin_off_nxt   = fin_off_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = 1'b0;
    cmd.op        = DP_NOP;
    cmd.fin_st    = fin_st_r;
    cmd.fin_off   = fin_off_r;
    case (state_r)
      // Clearing pass after reset
      S_CLR: begin
        cmd.op = DP_SWEEP;
        if (sts.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.req_type)
          REQ_ALLOC: begin
            if (sts.req_zero) begin
              fin_st_nxt  = ST_INVALID;
              fin_off_nxt = 1'b0;
              state_nxt   = S_FIN;
            end else begin
              state_nxt = S_A_RD;
            end
          end
          REQ_FREE: begin
            if (sts.off_bad) begin
              fin_st_nxt  = ST_INVALID;
              fin_off_nxt = 1'b0;
              state_nxt   = S_FIN;
            end else begin
              state_nxt = S_F_RDH;
            end
          end
          REQ_FORMAT: begin
            cmd.op    = DP_FMT_START;
            state_nxt = S_FMT;
          end
          default: begin
            fin_st_nxt  = ST_INVALID;
            fin_off_nxt = 1'b0;
            state_nxt   = S_FIN;
          end
        endcase
      end
      // Format: rewrite every word of the heap
      S_FMT: begin
        cmd.op = DP_SWEEP;
        if (sts.sweep_last) begin
          fin_st_nxt  = ST_OK;
          fin_off_nxt = 1'b0;
          state_nxt   = S_FIN;
        end
      end
      // First-fit walk, one block per read
      S_A_RD: begin
        if (sts.walk_end) begin
          fin_st_nxt  = ST_NOFIT;
          fin_off_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else begin
          cmd.op    = DP_A_RD;
          state_nxt = S_A_EV;
        end
      end
      S_A_EV: begin
        cmd.op = DP_A_EV;
        if (sts.alloc_broken) begin
          fin_st_nxt  = ST_NOFIT;
          fin_off_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else if (sts.alloc_fit) begin
          state_nxt = S_A_W0;
        end else begin
          state_nxt = S_A_RD;
        end
      end
      S_A_W0: begin
        cmd.op    = DP_A_W0;
        state_nxt = S_A_W1;
      end
      S_A_W1: begin
        cmd.op = DP_A_W1;
        if (sts.split) begin
          state_nxt = S_A_W2;
        end else begin
          fin_st_nxt  = ST_OK;
          fin_off_nxt = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_A_W2: begin
        cmd.op    = DP_A_W2;
        state_nxt = S_A_W3;
      end
      S_A_W3: begin
        cmd.op      = DP_A_W3;
        fin_st_nxt  = ST_OK;
        fin_off_nxt = 1'b1;
        state_nxt   = S_FIN;
      end
      // Free: check the block's tags, then probe the neighbors that lie inside the heap
      S_F_RDH: begin
        cmd.op    = DP_F_RDH;
        state_nxt = S_F_EVH;
      end
      S_F_EVH: begin
        cmd.op = DP_F_EVH;
        if (sts.hdr_bad) begin
          fin_st_nxt  = ST_INVALID;
          fin_off_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_F_RDF;
        end
      end
      S_F_RDF: begin
        cmd.op    = DP_F_RDF;
        state_nxt = S_F_EVF;
      end
      S_F_EVF: begin
        if (sts.ftr_bad) begin
          fin_st_nxt  = ST_INVALID;
          fin_off_nxt = 1'b0;
          state_nxt   = S_FIN;
        end else begin
          state_nxt = S_F_RDP;
        end
      end
      S_F_RDP: begin
        cmd.op    = DP_F_RDP;
        state_nxt = S_F_EVP;
      end
      S_F_EVP: begin
        cmd.op = DP_F_EVP;
        if (sts.prev_ok) begin
          state_nxt = S_F_RDQ;
        end else if (sts.next_ok) begin
          state_nxt = S_F_RDN;
        end else begin
          state_nxt = S_F_W0;
        end
      end
      S_F_RDQ: begin
        cmd.op    = DP_F_RDQ;
        state_nxt = S_F_EVQ;
      end
      S_F_EVQ: begin
        cmd.op = DP_F_EVQ;
        if (sts.next_ok) begin
          state_nxt = S_F_RDN;
        end else begin
          state_nxt = S_F_W0;
        end
      end
      S_F_RDN: begin
        cmd.op    = DP_F_RDN;
        state_nxt = S_F_EVN;
      end
      S_F_EVN: begin
        cmd.op    = DP_F_EVN;
        state_nxt = S_F_W0;
      end
      S_F_W0: begin
        cmd.op    = DP_F_W0;
        state_nxt = S_F_W1;
      end
      S_F_W1: begin
        cmd.op      = DP_F_W1;
        fin_st_nxt  = ST_OK;
        fin_off_nxt = 1'b0;
        state_nxt   = S_FIN;
      end
      // Hold the result until the output register is free
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = DP_FIN;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      fin_st_r    <= ST_OK;
      fin_off_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fin_st_r    <= fin_st_nxt;
      fin_off_r   <= fin_off_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: rtl/boundary_tag_first_fit_allocator_core.sv
// Top level of the boundary-tag first-fit heap allocator. The heap is a 4096-word memory
// of header/footer tagged blocks framed by allocated prologue and epilogue blocks. Each beat
// on the input channel is one request (allocate, free, format) and produces exactly one
// result beat. Requests are handled one at a time, but a new request is taken while the
// previous result still waits in the output register. Every memory read is split into an
// address step and a registered read-data step, so an allocate decodes, reads and checks
// each block it walks, then writes 2 or 4 tags; a free reads its own header and footer,
// then the neighbors' tags, then writes the merged tags, and stops after its own tags when
// they are rejected. A request rejected at decode goes straight to the result. A finished
// result waits for the output register to drain. Format rewrites the whole memory one word
// a cycle; after reset the same pass runs with the reset pool size while no request is accepted.
// The pool size register may be written at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module boundary_tag_first_fit_allocator_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [bta_pkg::SZ_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  bta_pkg::req_t            in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output bta_pkg::rsp_t            out_data
);
  import bta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bta_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

  // A nonzero offset only comes from a successful allocate, four bytes past an 8-byte boundary
  a_off_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.payload_offset != '0) |->
      (out_data.status == ST_OK && out_data.payload_offset[2:0] == 3'd4))
    else $error("nonzero payload offset with bad status or alignment");

  // No request is taken while the memory is being rewritten
  a_no_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == DP_SWEEP) |-> !in_ready)
    else $error("request accepted during clearing pass");

  // A result is never posted in the cycle right after a request beat
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (cmd.op != DP_FIN))
    else $error("result posted before request was decoded");

endmodule

`default_nettype wire

// File: tb/sv/bta_heap_checker.sv
// Checker for the boundary-tag heap allocator: mirrors the heap and compares result beats.
`timescale 1ns / 1ps

module bta_heap_checker (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [bta_pkg::SZ_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  bta_pkg::req_t            in_data,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  bta_pkg::rsp_t            out_data,
  output int                       mismatches,
  output int                       outstanding
);
  import bta_pkg::*;

  // Mirror of the heap memory and its framing
  logic [31:0]     heap_mem [HEAP_WORDS];
  longint unsigned heap_limit;
  logic [SZ_W-1:0] pool_reg;

  rsp_t due_rsp [$];
  int   fail_n = 0;
  int   due_n  = 0;

  assign mismatches  = fail_n;
  assign outstanding = due_n;

  task automatic report(string what);
    fail_n++;
    if (fail_n <= 40) begin
      $display("%0t ns  mismatch: %s", $time, what);
    end
  endtask

  // Words past the end of the memory read as zero
  function automatic logic [31:0] heap_rd(longint unsigned addr);
    longint unsigned w;
    w = addr >> 2;
    if (w < HEAP_WORDS) begin
      return heap_mem[int'(w)];
    end
    return '0;
  endfunction

  // Writes past the end of the memory are dropped
  function automatic void heap_wr(longint unsigned addr, logic [31:0] val);
    longint unsigned w;
    w = addr >> 2;
    if (w < HEAP_WORDS) begin
      heap_mem[int'(w)] = val;
    end
  endfunction

  // Write matching header and footer tags
  function automatic void put_tag(longint unsigned hdr, longint unsigned size, bit used);
    longint unsigned sz;
    logic [31:0]     v;
    sz = size & ~64'd7;
    v  = 32'(sz) | 32'(used);
    heap_wr(hdr, v);
    heap_wr(hdr + 4 + sz, v);
  endfunction

  // Clear the memory and lay out prologue, one free block and epilogue
  function automatic void lay_out_heap();
    longint unsigned cap;
    longint unsigned pool;
    cap  = (longint'(HEAP_WORDS) * 4 - 24) & ~64'd7;
    pool = 64'(pool_reg) & ~64'd7;
    if (pool > cap) begin
      pool = cap;
    end
    for (int i = 0; i < HEAP_WORDS; i++) begin
      heap_mem[i] = '0;
    end
    put_tag(0, 0, 1'b1);
    put_tag(8, pool, 1'b0);
    put_tag(16 + pool, 0, 1'b1);
    heap_limit = pool + 24;
  endfunction

  // First-fit walk from the first block; split when the slack exceeds one tag pair
  function automatic rsp_t carve_block(logic [SZ_W-1:0] req);
    rsp_t            r;
    longint unsigned need;
    longint unsigned p;
    longint unsigned s;
    longint unsigned take;
    logic [31:0]     h;
    r.payload_offset = '0;
    r.status         = ST_NOFIT;
    if (req == '0) begin
      r.status = ST_INVALID;
      return r;
    end
    need = (64'(req) + 7) & ~64'd7;
    p    = 8;
    while (p + 8 <= heap_limit) begin
      h = heap_rd(p);
      s = 64'(h) & ~64'd7;
      if (p + s + 8 > heap_limit) begin
        break;
      end
      if (!h[0] && s >= need) begin
        take = (s <= need + 8) ? s : need;
        put_tag(p, take, 1'b1);
        if (take < s) begin
          put_tag(p + take + 8, s - take - 8, 1'b0);
        end
        r.payload_offset = SZ_W'(p + 4);
        r.status         = ST_OK;
        return r;
      end
      p += s + 8;
    end
    return r;
  endfunction

  // Validate the block, then merge with whichever neighbors are free
  function automatic logic [ST_W-1:0] free_block(logic [SZ_W-1:0] off);
    longint unsigned hdr;
    longint unsigned size;
    longint unsigned ps;
    longint unsigned ns;
    longint unsigned phdr;
    longint unsigned nhdr;
    longint unsigned start_at;
    longint unsigned total;
    logic [31:0]     h;
    logic [31:0]     ph;
    logic [31:0]     nh;
    bit              prev_free;
    bit              next_free;
    prev_free = 1'b0;
    next_free = 1'b0;
    ns        = 0;
    phdr      = 0;
    if (off == '0 || off[2:0] != 3'd4 || off < 12) begin
      return ST_INVALID;
    end
    hdr  = 64'(off) - 4;
    h    = heap_rd(hdr);
    size = 64'(h) & ~64'd7;
    if (!h[0] || size == 0 || hdr + size + 8 > heap_limit ||
        heap_rd(hdr + 4 + size) != h) begin
      return ST_INVALID;
    end
    ps = 64'(heap_rd(hdr - 4)) & ~64'd7;
    if (ps + 8 <= hdr) begin
      phdr      = hdr - ps - 8;
      ph        = heap_rd(phdr);
      prev_free = !ph[0];
    end
    nhdr = hdr + size + 8;
    if (nhdr + 8 <= heap_limit) begin
      nh = heap_rd(nhdr);
      ns = 64'(nh) & ~64'd7;
      if (nhdr + ns + 8 <= heap_limit) begin
        next_free = !nh[0];
      end
    end
    start_at = hdr;
    total    = size;
    if (prev_free) begin
      start_at = phdr;
      total   += ps + 8;
    end
    if (next_free) begin
      total += ns + 8;
    end
    put_tag(start_at, total, 1'b0);
    return ST_OK;
  endfunction

  function automatic rsp_t outcome_of(req_t r);
    rsp_t o;
    o.payload_offset = '0;
    o.status         = ST_OK;
    case (r.req_type)
      REQ_ALLOC: begin
        o = carve_block(r.request_bytes);
      end
      REQ_FREE: begin
        o.status = free_block(r.block_offset);
      end
      REQ_FORMAT: begin
        lay_out_heap();
      end
      default: begin
        o.status = ST_INVALID;
      end
    endcase
    return o;
  endfunction

  // Track config, check result beats against the oldest prediction, predict new beats
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst_n) begin
      due_rsp.delete();
      pool_reg = POOL_RESET;
      lay_out_heap();
    end else begin
      if (cfg_wr_en) begin
        pool_reg = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        if (due_rsp.size() == 0) begin
          report($sformatf("result beat off=%0d st=%0d with nothing expected",
                           out_data.payload_offset, out_data.status));
        end else begin
          want = due_rsp.pop_front();
          if (out_data.payload_offset !== want.payload_offset) begin
            report($sformatf("payload_offset got %0d want %0d",
                             out_data.payload_offset, want.payload_offset));
          end
          if (out_data.status !== want.status) begin
            report($sformatf("status got %0d want %0d", out_data.status, want.status));
          end
        end
      end
      if (in_valid && in_ready) begin
        due_rsp.push_back(outcome_of(in_data));
      end
    end
    due_n = due_rsp.size();
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the boundary-tag heap allocator: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb;
  import bta_pkg::*;

  localparam logic [TYPE_W-1:0] REQ_BOGUS = TYPE_W'(3);

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic            clk         = 1'b0;
  logic            rst_n       = 1'b0;
  logic            cfg_wr_en   = 1'b0;
  logic [SZ_W-1:0] cfg_wr_data = '0;
  logic            in_valid    = 1'b0;
  logic            in_ready;
  req_t            in_data     = '0;
  logic            out_valid;
  logic            out_ready   = 1'b0;
  rsp_t            out_data;

  int mismatches;
  int outstanding;
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int cur_pool       = int'(POOL_RESET);

  // Offsets handed out and not yet freed, and the request kinds still in flight
  logic [SZ_W-1:0]   live_offs    [$];
  logic [TYPE_W-1:0] issued_kinds [$];

  int pool_plan [8] = '{8, 16360, 2048, 16383, 512, 4096, 256, 1024};

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  boundary_tag_first_fit_allocator_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  bta_heap_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // Stall the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Collect granted offsets so frees can target live blocks; drop them on format
  always @(posedge clk) begin : track
    logic [TYPE_W-1:0] kind;
    if (rst_n) begin
      if (out_valid && out_ready && issued_kinds.size() != 0) begin
        kind = issued_kinds.pop_front();
        if (kind == REQ_ALLOC && out_data.status == ST_OK) begin
          live_offs.push_back(out_data.payload_offset);
        end else if (kind == REQ_FORMAT) begin
          live_offs.delete();
        end
      end
      if (in_valid && in_ready) begin
        issued_kinds.push_back(in_data.req_type);
      end
    end
  end

  function automatic req_t mk(logic [TYPE_W-1:0] kind, int bytes, int off);
    req_t r;
    r.req_type      = kind;
    r.request_bytes = SZ_W'(bytes);
    r.block_offset  = SZ_W'(off);
    return r;
  endfunction

  function automatic void set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin
        send_gap_pct = 0;  recv_stall_pct = 0;
      end
      IDLE_SEND: begin
        send_gap_pct = 56; recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_gap_pct = 0;  recv_stall_pct = 56;
      end
      default: begin
        send_gap_pct = 22; recv_stall_pct = 22;
      end
    endcase
  endfunction

  // Mostly allocs of small sizes and frees of live blocks; some junk and formats
  function automatic req_t next_random_req();
    req_t r;
    int   roll;
    int   pick;
    int   span;
    r    = mk(REQ_ALLOC, int'($urandom), int'($urandom));
    roll = $urandom_range(99);
    if (roll < 52) begin
      case ($urandom_range(9))
        7, 8:    r.request_bytes = SZ_W'($urandom_range(600, 1));
        9:       r.request_bytes = SZ_W'($urandom);
        default: r.request_bytes = SZ_W'($urandom_range(48, 1));
      endcase
    end else if (roll < 90) begin
      r.req_type = REQ_FREE;
      if (live_offs.size() != 0 && $urandom_range(9) < 7) begin
        pick           = $urandom_range(live_offs.size() - 1);
        r.block_offset = live_offs[pick];
        // keep one in ten so it gets freed twice later
        if ($urandom_range(9) != 0) begin
          live_offs.delete(pick);
        end
      end else if ($urandom_range(1) == 1) begin
        // aligned guess in and just past the heap, may land on stale tags
        span           = (cur_pool + 24) / 8;
        r.block_offset = SZ_W'($urandom_range(span) * 8 + 4);
      end
    end else if (roll < 93) begin
      r.req_type = REQ_FORMAT;
    end else if (roll < 96) begin
      r.req_type = REQ_BOGUS;
    end else begin
      r.request_bytes = SZ_W'($urandom_range(16));
    end
    return r;
  endfunction

  // Hold the beat until accepted; idle beforehand at random
  task automatic push_req(req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and wait until every predicted result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_pool(int bytes);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= SZ_W'(bytes);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_pool     = bytes;
  endtask

  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks on the reset heap of 1024 bytes
    push_req(mk(REQ_ALLOC, 0, 0));          // zero request
    push_req(mk(REQ_ALLOC, 16383, 0));      // too big to fit
    push_req(mk(REQ_ALLOC, 1, 0));          // rounds up to 8, split
    push_req(mk(REQ_ALLOC, 8, 0));
    push_req(mk(REQ_ALLOC, 24, 0));
    push_req(mk(REQ_FREE, 0, 0));           // null offset
    push_req(mk(REQ_FREE, 0, 13));          // misaligned
    push_req(mk(REQ_FREE, 0, 4));           // prologue
    push_req(mk(REQ_FREE, 0, 16380));       // past heap end
    push_req(mk(REQ_FREE, 0, 20));          // not an allocated header
    push_req(mk(REQ_FREE, 0, 28));          // both neighbors allocated
    push_req(mk(REQ_FREE, 0, 28));          // double free
    push_req(mk(REQ_FREE, 0, 12));          // merge with next
    push_req(mk(REQ_FREE, 0, 44));          // merge with both sides
    push_req(mk(REQ_ALLOC, 1016, 0));       // slack of 8 takes the whole block
    push_req(mk(REQ_FREE, 0, 12));
    push_req(mk(REQ_ALLOC, 1008, 0));       // slack of 16 splits
    push_req(mk(REQ_FREE, 0, 12));
    push_req(mk(REQ_BOGUS, 16383, 16383));  // unknown request type
    push_req(mk(REQ_FORMAT, 0, 0));
    push_req(mk(REQ_ALLOC, 1024, 0));       // exact fit
    push_req(mk(REQ_ALLOC, 1, 0));          // heap full
    push_req(mk(REQ_FREE, 0, 12));

    // Random phases over pool sizes and flow-control modes
    for (int ph = 0; ph < 8; ph++) begin
      write_pool(pool_plan[ph]);
      set_idle(idle_mode_t'(ph % 4));
      push_req(mk(REQ_FORMAT, int'($urandom), int'($urandom)));
      repeat (190) push_req(next_random_req());
    end

    wait_idle();
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
